// ===== sv/ufst_pkg.sv =====
// shared types and constants for the union-find spanning tree filter
// no dependencies; used by ufst_ctrl, ufst_dpath and the top level
package ufst_pkg;

  localparam int unsigned NodeW    = 10;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned CfgReset = 1024;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the offered edge
    logic clr_wr;    // write one table entry of the clearing pass
    logic step;      // follow the parent pointer just read
    logic switch_b;  // root of node a found, start the walk from node b
    logic link;      // merge the two sets if the roots differ
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic eligible;
    logic root_hit;
  } status_t;

endpackage

// ===== sv/ufst_ctrl.sv =====
// controller state machine for the union-find spanning tree filter
// depends on ufst_pkg; drives ufst_dpath through cmd_t and reads status_t
module ufst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ufst_pkg::status_t status_i,
  output ufst_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              strobe_o
);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StElig   = 3'd2;
  localparam logic [2:0] StWalkA  = 3'd3;
  localparam logic [2:0] StWalkB  = 3'd4;
  localparam logic [2:0] StLink   = 3'd5;
  localparam logic [2:0] StResult = 3'd6;

  logic [2:0] st_q, st_d;

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clear_last) st_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          st_d       = StElig;
        end
      end
      StElig: begin
        // the read of node a's parent is issued in this cycle
        st_d = status_i.eligible ? StWalkA : StResult;
      end
      StWalkA: begin
        if (status_i.root_hit) begin
          cmd_o.switch_b = 1'b1;
          st_d           = StWalkB;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StWalkB: begin
        if (status_i.root_hit) begin
          st_d = StLink;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StLink: begin
        cmd_o.link = 1'b1;
        st_d       = StResult;
      end
      StResult: begin
        st_d = StIdle;
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
    end else begin
      st_q <= st_d;
    end
  end

  assign busy_o   = (st_q != StIdle);
  assign strobe_o = (st_q == StResult);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held longer than one cycle");

  a_start_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && start_i) |=> (st_q == StElig && busy_o))
    else $error("accepted edge did not enter the eligibility check");

  a_link_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StLink) |=> strobe_o)
    else $error("merge step not followed by the result");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClear && !status_i.clear_last) |=> (st_q == StClear && busy_o))
    else $error("clearing pass left early");

endmodule

// ===== sv/ufst_dpath.sv =====
// datapath of the union-find spanning tree filter: parent table memory,
// root walk cursor, tree edge counter and node count register; uses ufst_pkg
module ufst_dpath #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [ufst_pkg::CfgW-1:0]  cfg_node_count_i,
  input  logic [ufst_pkg::NodeW-1:0] node_a_i,
  input  logic [ufst_pkg::NodeW-1:0] node_b_i,
  input  ufst_pkg::cmd_t             cmd_i,
  output ufst_pkg::status_t          status_o,
  output logic                       accepted_o,
  output logic [ufst_pkg::NodeW-1:0] edge_a_o,
  output logic [ufst_pkg::NodeW-1:0] edge_b_o,
  output logic [ufst_pkg::NodeW-1:0] tree_edges_o,
  output logic                       done_res_o
);

  localparam int unsigned IdxW = $clog2(MAX_NODES);
  localparam int unsigned CmpW = ($clog2(MAX_NODES + 1) > ufst_pkg::CfgW) ?
                                 $clog2(MAX_NODES + 1) : ufst_pkg::CfgW;

  logic [ufst_pkg::CfgW-1:0]  cfg_q;
  logic [IdxW-1:0]            clr_q;
  logic [IdxW-1:0]            cnt_q;
  logic                       acc_q;
  logic [ufst_pkg::NodeW-1:0] a_q, b_q;
  logic [IdxW-1:0]            cur_q, ra_q;
  logic [IdxW-1:0]            rdata_q;
  logic [IdxW-1:0]            mem [MAX_NODES];

  logic [CmpW-1:0] n_eff, target, cnt_ext;
  logic [IdxW-1:0] raddr, waddr, wdata;
  logic            we, roots_differ;

  // node count saturated into [2, MAX_NODES]
  always_comb begin
    n_eff = CmpW'(cfg_q);
    if (n_eff < CmpW'(2)) begin
      n_eff = CmpW'(2);
    end else if (n_eff > CmpW'(MAX_NODES)) begin
      n_eff = CmpW'(MAX_NODES);
    end
  end

  assign target  = n_eff - CmpW'(1);
  assign cnt_ext = CmpW'(cnt_q);

  assign status_o.eligible   = (cnt_ext < target) && (CmpW'(a_q) < n_eff) &&
                               (CmpW'(b_q) < n_eff);
  assign status_o.root_hit   = (rdata_q == cur_q);
  assign status_o.clear_last = (clr_q == IdxW'(MAX_NODES - 1));

  // cur_q holds the root of node b during the link step
  assign roots_differ = (ra_q != cur_q);

  always_comb begin
    priority if (cmd_i.switch_b) begin
      raddr = IdxW'(b_q);
    end else if (cmd_i.step) begin
      raddr = rdata_q;
    end else begin
      raddr = cur_q;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ra_q;
    wdata = cur_q;
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = clr_q;
    end else if (cmd_i.link && roots_differ) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ufst_pkg::CfgW'(ufst_pkg::CfgReset);
      clr_q <= '0;
      cnt_q <= '0;
      acc_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_node_count_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + IdxW'(1);
      if (cmd_i.load) acc_q <= 1'b0;
      if (cmd_i.link && roots_differ) begin
        cnt_q <= cnt_q + IdxW'(1);
        acc_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      cur_q <= IdxW'(node_a_i);
    end else if (cmd_i.switch_b) begin
      ra_q  <= cur_q;
      cur_q <= IdxW'(b_q);
    end else if (cmd_i.step) begin
      cur_q <= rdata_q;
    end
  end

  assign accepted_o   = acc_q;
  assign edge_a_o     = a_q;
  assign edge_b_o     = b_q;
  assign tree_edges_o = ufst_pkg::NodeW'(cnt_q);
  assign done_res_o   = (cnt_ext >= target);

endmodule

// ===== sv/union_find_spanning_tree_filter.sv =====
// Spanning-tree edge filter over a union-find parent table.
// Channels: an edge (node_a_i, node_b_i) transfers at a clock edge with
// start_i high and busy_o low. One result per edge appears on the result
// ports for exactly one cycle with strobe_o high; the receiver cannot stall
// it and must take it in that cycle. The node count register is written
// through cfg_valid_i / cfg_ready_o (ready always high); the user must
// write it only while idle, which the block itself does not enforce.
// Sequence: an edge that is out of range or arrives after the tree is
// complete goes from the eligibility check straight to its result. Else the
// roots of node a and then node b are searched, the sets are merged if the
// roots differ and the result follows; the root walk reads one parent entry
// per cycle from the table memory (one read and one write port). busy_o
// falls in the cycle after the strobe, so the next edge can follow then.
// Reset: the count of tree edges clears and node count returns to 1024; the
// parent table is then swept to the identity, one entry per cycle, over all
// MAX_NODES entries with busy_o high.
// Depends on ufst_pkg, ufst_ctrl and ufst_dpath.
module union_find_spanning_tree_filter #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ufst_pkg::CfgW-1:0]  cfg_node_count_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [ufst_pkg::NodeW-1:0] node_a_i,
  input  logic [ufst_pkg::NodeW-1:0] node_b_i,
  output logic                       strobe_o,
  output logic                       accepted_o,
  output logic [ufst_pkg::NodeW-1:0] edge_a_o,
  output logic [ufst_pkg::NodeW-1:0] edge_b_o,
  output logic [ufst_pkg::NodeW-1:0] tree_edges_o,
  output logic                       done_res_o
);

  ufst_pkg::cmd_t    cmd;
  ufst_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ufst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .strobe_o (strobe_o)
  );

  ufst_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_node_count_i (cfg_node_count_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .accepted_o       (accepted_o),
    .edge_a_o         (edge_a_o),
    .edge_b_o         (edge_b_o),
    .tree_edges_o     (tree_edges_o),
    .done_res_o       (done_res_o)
  );

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for union_find_spanning_tree_filter: random edge streams
// checked against a behavioral union-find forest kept in the bench
// depends on ufst_pkg and the rtl top level
module testbench;

  localparam int unsigned NodeW    = ufst_pkg::NodeW;
  localparam int unsigned CfgW     = ufst_pkg::CfgW;
  localparam int unsigned MaxNodes = 1024;

  typedef enum logic {OP_EDGE, OP_SET_COUNT} offer_op_e;

  typedef struct {
    offer_op_e         op;
    logic [NodeW-1:0]  a;
    logic [NodeW-1:0]  b;
    logic [CfgW-1:0]   count;
    int                gap;
  } offer_t;

  typedef struct {
    logic             accepted;
    logic [NodeW-1:0] edge_a;
    logic [NodeW-1:0] edge_b;
    logic [NodeW-1:0] tree_edges;
    logic             done;
  } span_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_node_count_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [NodeW-1:0] node_a_i = '0;
  logic [NodeW-1:0] node_b_i = '0;
  logic             strobe_o;
  logic             accepted_o;
  logic [NodeW-1:0] edge_a_o;
  logic [NodeW-1:0] edge_b_o;
  logic [NodeW-1:0] tree_edges_o;
  logic             done_res_o;

  union_find_spanning_tree_filter #(
    .MAX_NODES(MaxNodes)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_node_count_i(cfg_node_count_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .strobe_o        (strobe_o),
    .accepted_o      (accepted_o),
    .edge_a_o        (edge_a_o),
    .edge_b_o        (edge_b_o),
    .tree_edges_o    (tree_edges_o),
    .done_res_o      (done_res_o)
  );

  initial forever #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // forest model and expected results
  // ---------------------------------------------------------------------------
  logic [NodeW-1:0] forest_parent [MaxNodes];
  int unsigned      tree_count;
  logic [CfgW-1:0]  node_limit;
  span_result_t     span_results_q [$];
  logic             results_waiting = 1'b0;
  int               mismatches = 0;

  function automatic int unsigned nodes_in_use(input int unsigned count);
    if (count < 2) return 2;
    if (count > MaxNodes) return MaxNodes;
    return count;
  endfunction

  function automatic logic [NodeW-1:0] forest_root(input logic [NodeW-1:0] node);
    logic [NodeW-1:0] cur;
    int               steps;
    cur = node;
    steps = 0;
    while (forest_parent[cur] != cur && steps < MaxNodes) begin
      cur = forest_parent[cur];
      steps++;
    end
    return cur;
  endfunction

  // root of a goes under root of b when the roots differ
  function automatic span_result_t span_predict(input logic [NodeW-1:0] a,
                                                input logic [NodeW-1:0] b);
    span_result_t     r;
    int unsigned      n;
    logic [NodeW-1:0] ra;
    logic [NodeW-1:0] rb;
    n = nodes_in_use(node_limit);
    r.accepted = 1'b0;
    if (tree_count < n - 1 && a < n && b < n) begin
      ra = forest_root(a);
      rb = forest_root(b);
      if (ra != rb) begin
        forest_parent[ra] = rb;
        tree_count++;
        r.accepted = 1'b1;
      end
    end
    r.edge_a = a;
    r.edge_b = b;
    r.tree_edges = tree_count[NodeW-1:0];
    r.done = (tree_count >= n - 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_result();
    span_result_t want;
    if (span_results_q.size() == 0) begin
      report_mismatch($sformatf("result with no edge waiting (a=%0d b=%0d)",
                                edge_a_o, edge_b_o));
      return;
    end
    want = span_results_q.pop_front();
    if (accepted_o !== want.accepted)
      report_mismatch($sformatf("accepted %b, want %b (edge %0d-%0d)",
                                accepted_o, want.accepted, want.edge_a, want.edge_b));
    if (edge_a_o !== want.edge_a)
      report_mismatch($sformatf("edge_a %0d, want %0d", edge_a_o, want.edge_a));
    if (edge_b_o !== want.edge_b)
      report_mismatch($sformatf("edge_b %0d, want %0d", edge_b_o, want.edge_b));
    if (tree_edges_o !== want.tree_edges)
      report_mismatch($sformatf("tree_edges %0d, want %0d (edge %0d-%0d)",
                                tree_edges_o, want.tree_edges, want.edge_a, want.edge_b));
    if (done_res_o !== want.done)
      report_mismatch($sformatf("done_res %b, want %b (edge %0d-%0d)",
                                done_res_o, want.done, want.edge_a, want.edge_b));
  endtask

  // monitor: check results, then track config and edge transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNodes; i++) forest_parent[i] = i[NodeW-1:0];
      tree_count = 0;
      node_limit = CfgW'(ufst_pkg::CfgReset);
      results_waiting <= 1'b0;
    end else begin
      if (strobe_o === 1'b1) check_result();
      if (cfg_valid_i && cfg_ready_o === 1'b1) node_limit = cfg_node_count_i;
      if (start_i && busy_o === 1'b0)
        span_results_q.push_back(span_predict(node_a_i, node_b_i));
      results_waiting <= (span_results_q.size() != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  offer_t pending_q [$];
  offer_t next_offer;
  int     waited = 0;
  logic   block_idle;

  // register writes only go out once the block has drained
  assign block_idle = !start_i && !cfg_valid_i && busy_o === 1'b0 && !results_waiting;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      node_a_i <= '0;
      node_b_i <= '0;
      cfg_node_count_i <= '0;
      waited <= 0;
    end else if ((start_i && busy_o !== 1'b0) || (cfg_valid_i && cfg_ready_o !== 1'b1)) begin
      // offer still waiting for its transfer
    end else if (pending_q.size() == 0) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else if (waited < pending_q[0].gap ||
                 (pending_q[0].op == OP_SET_COUNT && !block_idle)) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      waited <= waited + 1;
    end else begin
      next_offer = pending_q.pop_front();
      waited <= 0;
      if (next_offer.op == OP_EDGE) begin
        start_i <= 1'b1;
        cfg_valid_i <= 1'b0;
        node_a_i <= next_offer.a;
        node_b_i <= next_offer.b;
      end else begin
        start_i <= 1'b0;
        cfg_valid_i <= 1'b1;
        cfg_node_count_i <= next_offer.count;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  bit no_idle = 1'b0;
  bit gen_joined [MaxNodes];

  function automatic int draw_gap();
    if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic queue_edge(input logic [NodeW-1:0] a, input logic [NodeW-1:0] b);
    offer_t o;
    o.op = OP_EDGE;
    o.a = a;
    o.b = b;
    o.count = '0;
    o.gap = draw_gap();
    pending_q.push_back(o);
  endtask

  task automatic queue_node_count(input logic [CfgW-1:0] count);
    offer_t o;
    o.op = OP_SET_COUNT;
    o.a = '0;
    o.b = '0;
    o.count = count;
    o.gap = draw_gap();
    pending_q.push_back(o);
  endtask

  // growing phases attach unused nodes to the joined component one by one;
  // the rest is cycles, self loops, out-of-range ends and random pairs
  task automatic queue_phase(input int unsigned count, input int unsigned items,
                             input bit grow);
    int unsigned fresh [$];
    int unsigned joined [$];
    int unsigned n;
    int unsigned k;
    int unsigned u;
    int unsigned v;
    int unsigned roll;
    n = nodes_in_use(count);
    for (int i = 0; i < n; i++) begin
      if (gen_joined[i]) joined.push_back(i);
      else fresh.push_back(i);
    end
    queue_node_count(count[CfgW-1:0]);
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (grow && fresh.size() != 0 && roll < 75) begin
        k = $urandom_range(0, fresh.size() - 1);
        u = fresh[k];
        fresh.delete(k);
        v = joined[$urandom_range(0, joined.size() - 1)];
        gen_joined[u] = 1'b1;
        joined.push_back(u);
        // new node as b hangs the old root under it, which deepens the walks
        if ($urandom_range(0, 3) == 0) queue_edge(NodeW'(v), NodeW'(u));
        else queue_edge(NodeW'(u), NodeW'(v));
      end else if (roll < 82) begin
        u = $urandom_range(0, n - 1);
        queue_edge(NodeW'(u), NodeW'(u));
      end else if (roll < 90 && n < MaxNodes) begin
        u = $urandom_range(MaxNodes - 1, n);
        v = $urandom_range(0, MaxNodes - 1);
        if ($urandom_range(0, 1)) queue_edge(NodeW'(u), NodeW'(v));
        else queue_edge(NodeW'(v), NodeW'(u));
      end else begin
        u = $urandom_range(0, n - 1);
        v = $urandom_range(0, n - 1);
        queue_edge(NodeW'(u), NodeW'(v));
      end
    end
  endtask

  initial begin
    gen_joined[0] = 1'b1;

    // two-node graph: out-of-range ends, self loop, completion, edges after it
    queue_node_count(11'd0);
    queue_edge(10'd2, 10'd0);
    queue_edge(10'd0, 10'd1023);
    queue_edge(10'd1, 10'd1);
    queue_edge(10'd1, 10'd0);
    queue_edge(10'd0, 10'd1);
    queue_node_count(11'd1);
    queue_edge(10'd0, 10'd1);
    // all ones saturates to the full table
    queue_node_count(11'd2047);
    queue_edge(10'd1023, 10'd0);
    queue_edge(10'd0, 10'd1023);
    queue_edge(10'd1023, 10'd1023);
    queue_edge(10'd1022, 10'd1021);
    queue_edge(10'h2aa, 10'h155);
    queue_edge(10'h155, 10'h2aa);
    queue_edge(10'd1021, 10'd0);
    // shrinking below the tree size stops acceptance
    queue_node_count(11'd2);
    queue_edge(10'd5, 10'd6);
    queue_edge(10'd1, 10'd0);
    queue_node_count(11'd1025);
    queue_edge(10'h3fe, 10'd1);
    queue_edge(10'h155, 10'd3);

    queue_phase(16, 40, 1'b1);
    queue_phase(8, 10, 1'b0);
    queue_phase(64, 100, 1'b1);
    queue_phase(3, 10, 1'b0);
    queue_phase(200, 230, 1'b1);
    queue_phase(0, 10, 1'b0);
    queue_phase(500, 480, 1'b1);
    queue_phase(1024, 850, 1'b1);
    queue_phase(2047, 30, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start_i || cfg_valid_i) @(posedge clk_i);
    while (span_results_q.size() != 0) @(posedge clk_i);
    // longest walk is two full-depth root searches
    repeat (2 * MaxNodes + 64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
